### design/wst_pkg.sv
package wst_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // only the low four slots own a debug status bit
  localparam int HIT_SLOTS  = (SLOT_COUNT < 4) ? SLOT_COUNT : 4;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_ENABLE    = 3'd2,
    OP_HIT       = 3'd3,
    OP_INFO      = 3'd4,
    OP_RESET_CNT = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_LIMIT      = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FULL
  } ctrl_state_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    status_t     status;
    logic        hit;
    logic [31:0] id;
    logic [63:0] address;
    logic [3:0]  size;
    logic [1:0]  kind;
    logic        enabled;
    logic [31:0] hit_count;
    logic [1:0]  slot;
  } result_t;

endpackage

### design/wst_ctrl.sv
module wst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output wst_pkg::dp_cmd_t cmd
);
  import wst_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE) || out_ready;
    out_valid = (state_r == S_FULL);
    accept    = in_valid && in_ready;
    cmd.exec  = accept;
    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = S_FULL;
    end else if (out_ready) begin
      state_nxt = S_IDLE;
    end else begin
      state_nxt = state_r;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> (!cmd.exec ##1 out_valid))
    else $error("result dropped or overwritten while stalled");

endmodule

### design/wst_dp.sv
module wst_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  wst_pkg::dp_cmd_t cmd,
  input  logic [2:0]       in_operation,
  input  logic [63:0]      in_watch_address,
  input  logic [7:0]       in_watch_size,
  input  logic [1:0]       in_watch_type,
  input  logic [31:0]      in_watch_id,
  input  logic             in_enable_flag,
  input  logic [3:0]       in_status_bits,
  output wst_pkg::result_t res
);
  import wst_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] idx;
  } pick_t;

  function automatic pick_t first_set(input logic [SLOT_COUNT-1:0] v);
    pick_t p;
    p = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = SLOT_IDX_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [1:0] slot_code(input logic [SLOT_IDX_W-1:0] s);
    logic [3:0] wide;
    wide = 4'(s);
    return wide[1:0];
  endfunction

  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0] en_r, en_nxt;
  logic [31:0]           id_r    [SLOT_COUNT];
  logic [63:0]           addr_r  [SLOT_COUNT];
  logic [3:0]            size_r  [SLOT_COUNT];
  logic [1:0]            kind_r  [SLOT_COUNT];
  logic [31:0]           hits_r  [SLOT_COUNT];
  logic [31:0]           next_id_r, next_id_nxt;
  result_t               res_r, res_nxt;

  logic [SLOT_COUNT-1:0] free_v, match_v, hit_v;
  pick_t                 free_p, match_p, hit_p;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic                  size_ok;
  logic [2:0]            size_m1;
  logic                  wr_new, wr_en, wr_hits;
  logic [31:0]           hits_wval;
  op_t                   op;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_v[i]  = !used_r[i];
      match_v[i] = used_r[i] && (id_r[i] == in_watch_id);
      hit_v[i]   = 1'b0;
    end
    for (int i = 0; i < HIT_SLOTS; i++) begin
      hit_v[i] = in_status_bits[i] && used_r[i] && en_r[i];
    end
  end

  assign free_p  = first_set(free_v);
  assign match_p = first_set(match_v);
  assign hit_p   = first_set(hit_v);
  assign op      = op_t'(in_operation);
  assign rd_idx  = (op == OP_HIT) ? hit_p.idx : match_p.idx;
  assign size_ok = (in_watch_size == 8'd1) || (in_watch_size == 8'd2) ||
                   (in_watch_size == 8'd4) || (in_watch_size == 8'd8);
  assign size_m1 = 3'(in_watch_size - 8'd1);

  always_comb begin
    used_nxt    = used_r;
    en_nxt      = en_r;
    next_id_nxt = next_id_r;
    wr_new      = 1'b0;
    wr_en       = 1'b0;
    wr_hits     = 1'b0;
    hits_wval   = hits_r[rd_idx];
    res_nxt     = '0;
    res_nxt.status = ST_OK;
    unique case (op)
      OP_SET: begin
        priority if (in_watch_address == 64'd0 || !size_ok) begin
          res_nxt.status = ST_INVALID;
        end else if ((in_watch_address[2:0] & size_m1) != 3'd0) begin
          res_nxt.status = ST_MISALIGNED;
        end else if (!free_p.found) begin
          res_nxt.status = ST_LIMIT;
        end else begin
          wr_new                = 1'b1;
          used_nxt[free_p.idx]  = 1'b1;
          en_nxt[free_p.idx]    = 1'b1;
          next_id_nxt           = next_id_r + 32'd1;
          res_nxt.id            = next_id_r;
          res_nxt.address       = in_watch_address;
          res_nxt.size          = in_watch_size[3:0];
          res_nxt.kind          = in_watch_type;
          res_nxt.enabled       = 1'b1;
          res_nxt.slot          = slot_code(free_p.idx);
        end
      end
      OP_REMOVE, OP_ENABLE, OP_INFO, OP_RESET_CNT: begin
        if (!match_p.found) begin
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          res_nxt.id        = id_r[rd_idx];
          res_nxt.address   = addr_r[rd_idx];
          res_nxt.size      = size_r[rd_idx];
          res_nxt.kind      = kind_r[rd_idx];
          res_nxt.enabled   = en_r[rd_idx];
          res_nxt.hit_count = hits_r[rd_idx];
          res_nxt.slot      = slot_code(rd_idx);
          if (op == OP_REMOVE) begin
            used_nxt[rd_idx] = 1'b0;
          end
          if (op == OP_ENABLE) begin
            wr_en           = 1'b1;
            res_nxt.enabled = in_enable_flag;
          end
          if (op == OP_RESET_CNT) begin
            wr_hits           = 1'b1;
            hits_wval         = 32'd0;
            res_nxt.hit_count = 32'd0;
          end
        end
      end
      OP_HIT: begin
        if (hit_p.found) begin
          wr_hits           = 1'b1;
          hits_wval         = hits_r[rd_idx] + 32'd1;
          res_nxt.hit       = 1'b1;
          res_nxt.id        = id_r[rd_idx];
          res_nxt.address   = addr_r[rd_idx];
          res_nxt.size      = size_r[rd_idx];
          res_nxt.kind      = kind_r[rd_idx];
          res_nxt.enabled   = en_r[rd_idx];
          res_nxt.hit_count = hits_wval;
          res_nxt.slot      = slot_code(rd_idx);
        end
      end
      default: begin
        res_nxt.status = ST_INVALID;
      end
    endcase
    if (wr_en) begin
      en_nxt[rd_idx] = in_enable_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      en_r      <= '0;
      next_id_r <= '0;
      res_r     <= '0;
    end else if (cmd.exec) begin
      used_r    <= used_nxt;
      en_r      <= en_nxt;
      next_id_r <= next_id_nxt;
      res_r     <= res_nxt;
    end
  end

  // slot payload: written by set, hit count also by hit check and reset count
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_new) begin
      id_r[free_p.idx]   <= next_id_r;
      addr_r[free_p.idx] <= in_watch_address;
      size_r[free_p.idx] <= in_watch_size[3:0];
      kind_r[free_p.idx] <= in_watch_type;
      hits_r[free_p.idx] <= 32'd0;
    end else if (cmd.exec && wr_hits) begin
      hits_r[rd_idx] <= hits_wval;
    end
  end

  assign res = res_r;

  a_id_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(next_id_r))
    else $error("next id moved without an operation");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.hit |-> (res_r.status == ST_OK))
    else $error("hit reported with error status");

  a_limit_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.status == ST_LIMIT) |-> (&used_r))
    else $error("limit reported while a slot is free");

endmodule

### design/watchpoint_slot_table_core.sv
// Latency: a result is valid the cycle after its input beat is accepted.
// Throughput: one operation per cycle while out_ready stays high; the slot
// compares, first-free and first-hit encoders all settle within that cycle.
// A stalled result holds in the output register and blocks further input.
// Reset (rst_n low, synchronous) frees all slots, clears the enable bits
// and the id counter, and drops any pending result.
module watchpoint_slot_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_watch_address,
  input  logic [7:0]  in_watch_size,
  input  logic [1:0]  in_watch_type,
  input  logic [31:0] in_watch_id,
  input  logic        in_enable_flag,
  input  logic [3:0]  in_status_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_hit,
  output logic [31:0] out_id,
  output logic [63:0] out_address,
  output logic [3:0]  out_size,
  output logic [1:0]  out_type,
  output logic        out_enabled,
  output logic [31:0] out_hit_count,
  output logic [1:0]  out_slot
);
  import wst_pkg::*;

  dp_cmd_t cmd;
  result_t res;

  wst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  wst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_watch_address (in_watch_address),
    .in_watch_size    (in_watch_size),
    .in_watch_type    (in_watch_type),
    .in_watch_id      (in_watch_id),
    .in_enable_flag   (in_enable_flag),
    .in_status_bits   (in_status_bits),
    .res              (res)
  );

  assign out_status    = res.status;
  assign out_hit       = res.hit;
  assign out_id        = res.id;
  assign out_address   = res.address;
  assign out_size      = res.size;
  assign out_type      = res.kind;
  assign out_enabled   = res.enabled;
  assign out_hit_count = res.hit_count;
  assign out_slot      = res.slot;

endmodule
